[hdl/filtered_group_sum_aggregator_defines.svh]
// ----------------------------------------------------------------------------
// Filtered group-sum aggregator assertion macros
// Shared assertion forms, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef FILTERED_GROUP_SUM_AGGREGATOR_DEFINES_SVH
`define FILTERED_GROUP_SUM_AGGREGATOR_DEFINES_SVH

// same-cycle implication
`define FGSA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fgsa assertion failed");

// next-cycle implication
`define FGSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fgsa assertion failed");

`endif

[hdl/fgsa_pkg.sv]
// ----------------------------------------------------------------------------
// Filtered group-sum aggregator package
// Word types, divider constants and register map shared by all modules.
// ----------------------------------------------------------------------------
package fgsa_pkg;

  typedef struct packed {
    logic        command;
    logic [15:0] ship_date;
    logic [15:0] quantity;
    logic [23:0] price;
    logic [6:0]  discount;
    logic [6:0]  tax;
    logic [1:0]  return_flag;
    logic        line_status;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  group_flag;
    logic        group_status;
    logic [31:0] row_count;
    logic [62:0] sum_quantity;
    logic [62:0] sum_base_price;
    logic [62:0] sum_discounted_price;
    logic [62:0] sum_total_charge;
    logic        last_group;
  } out_word_t;

  localparam int GROUP_W = 4;

  // classified operation passed from front to back
  typedef struct packed {
    logic               finish;
    logic [GROUP_W-1:0] group;
    logic [15:0]        quantity;
    logic [23:0]        price;
    logic [30:0]        discounted;
    logic [38:0]        charge;
  } op_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam int PCT       = 100;
  localparam int PCT_SQ    = 10000;
  localparam int REM_PCT_W = 7;
  localparam int REM_SQ_W  = 14;
  localparam int DIV_W     = 64;
  localparam int DIV_DIGIT = 4;
  localparam int DIV_STEPS = DIV_W / DIV_DIGIT;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_DATE_CUTOFF = 1'b0;
  localparam logic [15:0] DATE_CUTOFF_RESET = 16'd18500;

endpackage

[hdl/fgsa_front.sv]
// ----------------------------------------------------------------------------
// Filtered group-sum aggregator front end
// Filters rows, forms the group key and computes both weighted prices.
// ----------------------------------------------------------------------------
module fgsa_front #(
  parameter int NUM_FLAGS    = 3,
  parameter int NUM_STATUSES = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fgsa_pkg::in_word_t word_i,
  output logic              full_o,
  input  logic [15:0]       cutoff_i,
  output logic              q_push_o,
  output fgsa_pkg::op_t     q_op_o,
  input  logic              q_full_i
);

  logic        a_valid_q;
  logic        a_finish_q;
  logic [fgsa_pkg::GROUP_W-1:0] a_group_q;
  logic [15:0] a_qty_q;
  logic [23:0] a_price_q;
  logic [30:0] a_disc_q;
  logic [7:0]  a_tfac_q;

  logic        accept;
  logic        qualify;
  logic        advance;
  logic [6:0]  disc_sat;
  logic [6:0]  dfac;
  logic [30:0] disc_prod;
  logic [fgsa_pkg::GROUP_W-1:0] group;

  assign full_o  = a_valid_q && q_full_i;
  assign accept  = push_i && !full_o;
  assign advance = !a_valid_q || !q_full_i;

  assign qualify = word_i.command ||
                   ((word_i.ship_date <= cutoff_i) &&
                    (3'(word_i.return_flag) < 3'(NUM_FLAGS)) &&
                    (3'(word_i.line_status) < 3'(NUM_STATUSES)));

  assign disc_sat  = (word_i.discount > 7'(fgsa_pkg::PCT)) ? 7'(fgsa_pkg::PCT)
                                                            : word_i.discount;
  assign dfac      = 7'(fgsa_pkg::PCT) - disc_sat;
  assign disc_prod = {7'b0, word_i.price} * {24'b0, dfac};
  assign group     = fgsa_pkg::GROUP_W'(word_i.return_flag) *
                     fgsa_pkg::GROUP_W'(NUM_STATUSES) +
                     fgsa_pkg::GROUP_W'(word_i.line_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q <= accept && qualify;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && accept) begin
      a_finish_q <= word_i.command;
      a_group_q  <= group;
      a_qty_q    <= word_i.quantity;
      a_price_q  <= word_i.price;
      a_disc_q   <= disc_prod;
      a_tfac_q   <= {1'b0, word_i.tax} + 8'(fgsa_pkg::PCT);
    end
  end

  assign q_push_o          = a_valid_q && !q_full_i;
  assign q_op_o.finish     = a_finish_q;
  assign q_op_o.group      = a_group_q;
  assign q_op_o.quantity   = a_qty_q;
  assign q_op_o.price      = a_price_q;
  assign q_op_o.discounted = a_disc_q;
  assign q_op_o.charge     = {8'b0, a_disc_q} * {31'b0, a_tfac_q};

endmodule

[hdl/fgsa_fifo.sv]
// ----------------------------------------------------------------------------
// Filtered group-sum aggregator operation queue
// Short register queue decoupling the front end from the group update.
// ----------------------------------------------------------------------------
module fgsa_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fgsa_pkg::op_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output fgsa_pkg::op_t data_o,
  output logic          empty_o
);

  fgsa_pkg::op_t mem_q [fgsa_pkg::QUEUE_DEPTH];
  logic [fgsa_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [fgsa_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [fgsa_pkg::QUEUE_PTR_W:0]   count_q;

  assign full_o  = (count_q == (fgsa_pkg::QUEUE_PTR_W + 1)'(fgsa_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hdl/fgsa_back.sv]
// ----------------------------------------------------------------------------
// Filtered group-sum aggregator back end
// Group accumulators, emit sequencer with constant dividers, result register.
// ----------------------------------------------------------------------------
module fgsa_back #(
  parameter int NUM_FLAGS    = 3,
  parameter int NUM_STATUSES = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fgsa_pkg::op_t       q_op_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                emit_busy_o,
  output logic                empty_o,
  input  logic                pop_i,
  output fgsa_pkg::out_word_t out_word_o
);

  localparam int NG = NUM_FLAGS * NUM_STATUSES;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_SEND
  } state_e;

  state_e state_q;

  logic [31:0] cnt_q  [NG];
  logic [62:0] qsum_q [NG];
  logic [62:0] psum_q [NG];
  logic [62:0] dsum_q [NG];
  logic [62:0] csum_q [NG];

  logic [GW-1:0] k_q;
  logic [1:0]    f_q;
  logic [1:0]    s_q;
  logic [fgsa_pkg::STEP_W-1:0] step_q;

  logic [31:0] cnt_hold_q;
  logic [62:0] qs_hold_q;
  logic [62:0] ps_hold_q;
  logic [fgsa_pkg::DIV_W-1:0] dq_q, dq_d;
  logic [fgsa_pkg::DIV_W-1:0] cq_q, cq_d;
  logic [fgsa_pkg::REM_PCT_W-1:0] rd_q, rd_d;
  logic [fgsa_pkg::REM_SQ_W-1:0]  rc_q, rc_d;

  logic                out_valid_q;
  fgsa_pkg::out_word_t out_word_q;

  logic last;
  logic out_free;

  assign q_pop_o     = (state_q == ST_RUN) && !q_empty_i;
  assign emit_busy_o = (state_q != ST_RUN);
  assign empty_o     = !out_valid_q;
  assign out_word_o  = out_word_q;
  assign last        = (k_q == GW'(NG - 1));
  assign out_free    = !out_valid_q || pop_i;

  // restoring division, DIV_DIGIT quotient bits per cycle
  always_comb begin
    logic [fgsa_pkg::REM_PCT_W:0] td;
    logic [fgsa_pkg::REM_SQ_W:0]  tc;
    rd_d = rd_q;
    rc_d = rc_q;
    dq_d = dq_q << fgsa_pkg::DIV_DIGIT;
    cq_d = cq_q << fgsa_pkg::DIV_DIGIT;
    for (int i = 0; i < fgsa_pkg::DIV_DIGIT; i++) begin
      td = {rd_d, dq_q[fgsa_pkg::DIV_W-1-i]};
      if (td >= (fgsa_pkg::REM_PCT_W + 1)'(fgsa_pkg::PCT)) begin
        td = td - (fgsa_pkg::REM_PCT_W + 1)'(fgsa_pkg::PCT);
        dq_d[fgsa_pkg::DIV_DIGIT-1-i] = 1'b1;
      end
      rd_d = td[fgsa_pkg::REM_PCT_W-1:0];
      tc = {rc_d, cq_q[fgsa_pkg::DIV_W-1-i]};
      if (tc >= (fgsa_pkg::REM_SQ_W + 1)'(fgsa_pkg::PCT_SQ)) begin
        tc = tc - (fgsa_pkg::REM_SQ_W + 1)'(fgsa_pkg::PCT_SQ);
        cq_d[fgsa_pkg::DIV_DIGIT-1-i] = 1'b1;
      end
      rc_d = tc[fgsa_pkg::REM_SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      f_q         <= '0;
      s_q         <= '0;
      step_q      <= '0;
      for (int g = 0; g < NG; g++) begin
        cnt_q[g]  <= '0;
        qsum_q[g] <= '0;
        psum_q[g] <= '0;
        dsum_q[g] <= '0;
        csum_q[g] <= '0;
      end
    end else begin
      if (out_valid_q && pop_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_RUN: begin
          if (!q_empty_i) begin
            if (q_op_i.finish) begin
              k_q     <= '0;
              f_q     <= '0;
              s_q     <= '0;
              state_q <= ST_LOAD;
            end else begin
              for (int g = 0; g < NG; g++) begin
                if (q_op_i.group == fgsa_pkg::GROUP_W'(g)) begin
                  cnt_q[g]  <= cnt_q[g] + 32'd1;
                  qsum_q[g] <= qsum_q[g] + 63'(q_op_i.quantity);
                  psum_q[g] <= psum_q[g] + 63'(q_op_i.price);
                  dsum_q[g] <= dsum_q[g] + 63'(q_op_i.discounted);
                  csum_q[g] <= csum_q[g] + 63'(q_op_i.charge);
                end
              end
            end
          end
        end
        ST_LOAD: begin
          cnt_hold_q <= cnt_q[k_q];
          qs_hold_q  <= qsum_q[k_q];
          ps_hold_q  <= psum_q[k_q];
          dq_q       <= {1'b0, dsum_q[k_q]};
          cq_q       <= {1'b0, csum_q[k_q]};
          rd_q       <= '0;
          rc_q       <= '0;
          step_q     <= '0;
          cnt_q[k_q]  <= '0;
          qsum_q[k_q] <= '0;
          psum_q[k_q] <= '0;
          dsum_q[k_q] <= '0;
          csum_q[k_q] <= '0;
          state_q    <= ST_DIV;
        end
        ST_DIV: begin
          dq_q   <= dq_d;
          cq_q   <= cq_d;
          rd_q   <= rd_d;
          rc_q   <= rc_d;
          step_q <= step_q + 1'b1;
          if (step_q == fgsa_pkg::STEP_W'(fgsa_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (out_free) begin
            out_valid_q                     <= 1'b1;
            out_word_q.group_flag           <= f_q;
            out_word_q.group_status         <= s_q[0];
            out_word_q.row_count            <= cnt_hold_q;
            out_word_q.sum_quantity         <= qs_hold_q;
            out_word_q.sum_base_price       <= ps_hold_q;
            out_word_q.sum_discounted_price <= dq_q[62:0];
            out_word_q.sum_total_charge     <= cq_q[62:0];
            out_word_q.last_group           <= last;
            if (last) begin
              state_q <= ST_RUN;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_LOAD;
              if (s_q == 2'(NUM_STATUSES - 1)) begin
                s_q <= '0;
                f_q <= f_q + 1'b1;
              end else begin
                s_q <= s_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

endmodule

[hdl/filtered_group_sum_aggregator.sv]
// ----------------------------------------------------------------------------
// Filtered group-sum aggregator
// Pricing summary over order line rows, grouped by return flag and status.
// ----------------------------------------------------------------------------
// Input side is a queue: a word is taken when push is high and full is low.
// An accumulate word whose ship date is at or below date_cutoff and whose
// key is in range updates its group; other accumulate words are dropped.
// A finish word emits NUM_FLAGS*NUM_STATUSES result words, flag-major, the
// last one marked by last_group, and clears each group as it is read.
// Result side is a queue: the head word is valid while empty is low and is
// taken when pop is high.
// Throughput: one accumulate word per cycle unless an emit holds the queue,
// set by the read-modify-write of the group registers. A word reaches the sums
// via the front register, the queue and the group update. The two constant
// dividers retire four quotient bits a cycle. Rows pushed meanwhile wait in
// the queue. A stalled receiver holds the emit sequence, then the queue and
// finally raises full. Reset clears all sums, sets date_cutoff to 18500.
// date_cutoff is at APB byte address 0 and is to be written only while the
// block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "filtered_group_sum_aggregator_defines.svh"

module filtered_group_sum_aggregator #(
  parameter int NUM_FLAGS    = 3,
  parameter int NUM_STATUSES = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  fgsa_pkg::in_word_t          in_word_i,
  output logic                        empty,
  input  logic                        pop,
  output fgsa_pkg::out_word_t         out_word_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fgsa_pkg::APB_AW-1:0] paddr,
  input  logic [fgsa_pkg::APB_DW-1:0] pwdata,
  output logic [fgsa_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  logic [15:0]   cutoff_q;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  logic          emit_busy;
  fgsa_pkg::op_t q_in;
  fgsa_pkg::op_t q_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fgsa_pkg::REG_DATE_CUTOFF) ?
                  {16'b0, cutoff_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= fgsa_pkg::DATE_CUTOFF_RESET;
    end else if (psel && penable && pwrite &&
                 (paddr[2] == fgsa_pkg::REG_DATE_CUTOFF)) begin
      cutoff_q <= pwdata[15:0];
    end
  end

  fgsa_front #(
    .NUM_FLAGS    (NUM_FLAGS),
    .NUM_STATUSES (NUM_STATUSES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .word_i   (in_word_i),
    .full_o   (full),
    .cutoff_i (cutoff_q),
    .q_push_o (q_push),
    .q_op_o   (q_in),
    .q_full_i (q_full)
  );

  fgsa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  fgsa_back #(
    .NUM_FLAGS    (NUM_FLAGS),
    .NUM_STATUSES (NUM_STATUSES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_op_i      (q_out),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .emit_busy_o (emit_busy),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_word_o  (out_word_o)
  );

  `FGSA_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty && !emit_busy)
  `FGSA_ASSERT_NEXT(a_finish_emits, q_pop && q_out.finish, emit_busy)
  `FGSA_ASSERT_IMPL(a_last_key, !empty && out_word_o.last_group, (out_word_o.group_flag == 2'(NUM_FLAGS - 1)) && (out_word_o.group_status == 1'(NUM_STATUSES - 1)))

endmodule

[test/tb_filtered_group_sum_aggregator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered group-sum aggregator testbench
// Streams order line rows and finish commands through the input queue, keeps
// its own per-group sums, and checks every emitted group word field by field
// under several cutoff settings and with random gaps on both queue sides.
// ----------------------------------------------------------------------------
module tb_filtered_group_sum_aggregator;
  import fgsa_pkg::*;

  localparam int NUM_FLAGS    = 3;
  localparam int NUM_STATUSES = 2;
  localparam int NUM_GROUPS   = NUM_FLAGS * NUM_STATUSES;
  localparam logic CMD_ACCUM  = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
  localparam logic [APB_AW-1:0] CUTOFF_ADDR = APB_AW'({REG_DATE_CUTOFF, 2'b00});
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ROWS_PER_PHASE = 120;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  in_word_t          in_word_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  out_word_t         out_word_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  filtered_group_sum_aggregator #(
    .NUM_FLAGS   (NUM_FLAGS),
    .NUM_STATUSES(NUM_STATUSES)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_word_i (in_word_i),
    .empty     (empty),
    .pop       (pop),
    .out_word_o(out_word_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // group accumulators of the predictor
  logic [31:0] grp_count  [NUM_GROUPS];
  logic [62:0] grp_qty    [NUM_GROUPS];
  logic [62:0] grp_price  [NUM_GROUPS];
  logic [62:0] grp_disc   [NUM_GROUPS];
  logic [62:0] grp_charge [NUM_GROUPS];
  logic [15:0] cutoff_model = DATE_CUTOFF_RESET;

  out_word_t pending_groups[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_filtered_group_sum_aggregator: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(string field, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_word_t exp_w;
    if (rst_ni && pop && !empty) begin
      if (pending_groups.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, got %h", $time, out_word_o);
      end else begin
        exp_w = pending_groups.pop_front();
        check_field("group_flag", exp_w.group_flag, out_word_o.group_flag);
        check_field("group_status", exp_w.group_status, out_word_o.group_status);
        check_field("row_count", exp_w.row_count, out_word_o.row_count);
        check_field("sum_quantity", exp_w.sum_quantity, out_word_o.sum_quantity);
        check_field("sum_base_price", exp_w.sum_base_price, out_word_o.sum_base_price);
        check_field("sum_discounted_price", exp_w.sum_discounted_price,
                    out_word_o.sum_discounted_price);
        check_field("sum_total_charge", exp_w.sum_total_charge,
                    out_word_o.sum_total_charge);
        check_field("last_group", exp_w.last_group, out_word_o.last_group);
      end
    end
  end

  task automatic clear_groups();
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_count[g]  = '0;
      grp_qty[g]    = '0;
      grp_price[g]  = '0;
      grp_disc[g]   = '0;
      grp_charge[g] = '0;
    end
  endtask

  // update the group sums for one accepted word, queue group words on finish
  task automatic aggregate_word(in_word_t w);
    int          g;
    logic [6:0]  disc;
    logic [30:0] disc_px;
    logic [38:0] charge;
    out_word_t   o;
    if (w.command == CMD_FINISH) begin
      for (int f = 0; f < NUM_FLAGS; f++) begin
        for (int s = 0; s < NUM_STATUSES; s++) begin
          g = f * NUM_STATUSES + s;
          o.group_flag           = 2'(f);
          o.group_status         = 1'(s);
          o.row_count            = grp_count[g];
          o.sum_quantity         = grp_qty[g];
          o.sum_base_price       = grp_price[g];
          o.sum_discounted_price = grp_disc[g] / 63'd100;
          o.sum_total_charge     = grp_charge[g] / 63'd10000;
          o.last_group           = (g == NUM_GROUPS - 1);
          pending_groups.push_back(o);
        end
      end
      clear_groups();
    end else if (w.ship_date <= cutoff_model && w.return_flag < NUM_FLAGS &&
                 w.line_status < NUM_STATUSES) begin
      g = int'(w.return_flag) * NUM_STATUSES + int'(w.line_status);
      disc = (w.discount > 7'd100) ? 7'd100 : w.discount;
      disc_px = 31'(w.price) * 31'(7'd100 - disc);
      charge  = 39'(disc_px) * 39'(w.tax + 8'd100);
      grp_count[g]  = grp_count[g] + 32'd1;
      grp_qty[g]    = grp_qty[g] + 63'(w.quantity);
      grp_price[g]  = grp_price[g] + 63'(w.price);
      grp_disc[g]   = grp_disc[g] + 63'(disc_px);
      grp_charge[g] = grp_charge[g] + 63'(charge);
    end
  endtask

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    aggregate_word(w);
  endtask

  task automatic drain(int settle);
    push <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_cutoff(logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CUTOFF_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cutoff_model = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("date_cutoff readback", cutoff_model, prdata[15:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic in_word_t mk_row(logic [15:0] ship, logic [15:0] qty,
                                      logic [23:0] price, logic [6:0] disc,
                                      logic [6:0] tax, logic [1:0] flag, logic status);
    in_word_t w;
    w.command     = CMD_ACCUM;
    w.ship_date   = ship;
    w.quantity    = qty;
    w.price       = price;
    w.discount    = disc;
    w.tax         = tax;
    w.return_flag = flag;
    w.line_status = status;
    return w;
  endfunction

  function automatic in_word_t mk_finish();
    in_word_t w;
    w = in_word_t'({$urandom, $urandom, $urandom});
    w.command = CMD_FINISH;
    return w;
  endfunction

  function automatic in_word_t rand_row();
    in_word_t w;
    w = in_word_t'({$urandom, $urandom, $urandom});
    w.command = CMD_ACCUM;
    case ($urandom_range(3))
      0: w.ship_date = 16'($urandom);
      1: w.ship_date = 16'(cutoff_model + $urandom_range(8) - 4);
      default: w.ship_date = 16'($urandom_range(cutoff_model, 0));
    endcase
    case ($urandom_range(9))
      0: w.price = '1;
      1: w.price = '0;
      default: ;
    endcase
    w.discount = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 101))
                                          : 7'($urandom_range(100));
    w.tax      = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 101))
                                          : 7'($urandom_range(100));
    w.return_flag = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(NUM_FLAGS - 1));
    return w;
  endfunction

  task automatic test_empty_finish();
    send_word(mk_finish());
    send_word(mk_finish());
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_directed_rows();
    send_word(mk_row(16'd18500, '1, '1, 7'd0, 7'd100, 2'd0, 1'b0));
    send_word(mk_row(16'd18501, '1, '1, 7'd0, 7'd0, 2'd0, 1'b0));
    send_word(mk_row(16'd0, 16'd0, 24'd0, 7'd0, 7'd0, 2'd0, 1'b1));
    send_word(mk_row(16'd0, 16'd7, 24'd1000, 7'd10, 7'd10, 2'd3, 1'b0));
    send_word(mk_row(16'd100, 16'd3, '1, 7'd127, 7'd127, 2'd1, 1'b0));
    send_word(mk_row(16'd200, 16'd9, 24'd99999, 7'd100, 7'd0, 2'd1, 1'b1));
    send_word(mk_row(16'd300, 16'd1, 24'd55555, 7'd101, 7'd50, 2'd2, 1'b0));
    send_word(mk_row(16'd400, 16'd2, 24'd12345, 7'd1, 7'd1, 2'd2, 1'b1));
    send_word(mk_row(16'd500, '1, '1, 7'd50, 7'd127, 2'd1, 1'b0));
    send_word(mk_finish());
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_cutoff_extremes();
    write_cutoff(16'd0);
    send_word(mk_row(16'd0, 16'd11, 24'd777, 7'd5, 7'd8, 2'd0, 1'b0));
    send_word(mk_row(16'd1, 16'd11, 24'd777, 7'd5, 7'd8, 2'd0, 1'b0));
    send_word(mk_row(16'hFFFF, 16'd11, 24'd777, 7'd5, 7'd8, 2'd2, 1'b1));
    send_word(mk_finish());
    drain(SETTLE_CYCLES);
    write_cutoff(16'hFFFF);
    send_word(mk_row(16'hFFFF, '1, '1, 7'd0, 7'd127, 2'd2, 1'b1));
    send_word(mk_row(16'd0, 16'd4, 24'd4321, 7'd20, 7'd20, 2'd1, 1'b1));
    send_word(mk_finish());
    drain(SETTLE_CYCLES);
  endtask

  task automatic test_random_phase(logic [15:0] cutoff, int idle_pct, int stall_pct);
    write_cutoff(cutoff);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < ROWS_PER_PHASE; i++) begin
      if ($urandom_range(14) == 0) send_word(mk_finish());
      else send_word(rand_row());
    end
    send_word(mk_finish());
    drain(SETTLE_CYCLES);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    clear_groups();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_finish();
    test_directed_rows();
    test_cutoff_extremes();
    test_random_phase(16'($urandom), 0, 0);
    test_random_phase(DATE_CUTOFF_RESET, 71, 0);
    test_random_phase(16'($urandom), 0, 71);
    test_random_phase(16'hFFFF, 30, 30);
    drain(4 * SETTLE_CYCLES);
    if (mismatch_count == 0) begin
      $display("tb_filtered_group_sum_aggregator: clean");
    end else begin
      $display("tb_filtered_group_sum_aggregator: errors");
    end
    $finish;
  end

endmodule
